FILE: rtl/core/phm_pkg.sv
// Shared types and constants for the peak-hold channel activity monitor.
// No dependencies; used by the config register block and the top level.
package phm_pkg;

    localparam int NUM_CHANNELS_DEF = 128;
    localparam int APB_ADDR_W       = 4;

    localparam logic [12:0] ENERGY_MAX = 13'h1FFF;
    localparam logic [15:0] MS_MAX     = 16'hFFFF;

    localparam logic [12:0] THRESH_RST = 13'd800;
    localparam logic [15:0] HOLD_RST   = 16'd2500;
    localparam logic [15:0] DECAY_RST  = 16'd4000;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [1:0] {
        REG_THRESH = 2'd0,
        REG_HOLD   = 2'd1,
        REG_DECAY  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DECAY
    } t_walk_state;

    typedef struct packed {
        logic [12:0] energy_threshold;
        logic [15:0] alert_hold_ms;
        logic [15:0] decay_period_ms;
    } t_cfg;

    typedef struct packed {
        logic       cmd;
        logic [6:0] channel;
        logic [5:0] carrier_count;
        logic       sweep_end;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  peak_level;
        logic [12:0] sweep_energy;
        logic        alert_active;
    } t_out_item;

endpackage

FILE: rtl/core/phm_stream_if.sv
// Valid/ready stream channel carrying one payload of type T.
// No dependencies; payload type is supplied at instantiation.
interface phm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/phm_cfg_regs.sv
// APB-style configuration registers: threshold, alert hold, decay period.
// Depends on phm_pkg (t_cfg, register indexes, reset values).
module phm_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [phm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output phm_pkg::t_cfg                  o_cfg
);
    import phm_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.energy_threshold <= THRESH_RST;
            r_cfg.alert_hold_ms    <= HOLD_RST;
            r_cfg.decay_period_ms  <= DECAY_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_THRESH: r_cfg.energy_threshold <= pwdata[12:0];
                REG_HOLD:   r_cfg.alert_hold_ms    <= pwdata[15:0];
                REG_DECAY:  r_cfg.decay_period_ms  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_THRESH: prdata = 32'(r_cfg.energy_threshold);
            REG_HOLD:   prdata = 32'(r_cfg.alert_hold_ms);
            REG_DECAY:  prdata = 32'(r_cfg.decay_period_ms);
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/peak_hold_channel_activity_monitor.sv
// Top level: per-channel peak store in a RAM with registered read data, sweep energy,
// alert hold and decay timers. Depends on phm_pkg, phm_stream_if, phm_cfg_regs.
//
//   port     dir   handshake       carries
//   i_req    in    valid/ready     cmd, channel, carrier_count, sweep_end
//   o_rsp    out   valid/ready     peak_level, sweep_energy, alert_active
//   apb      in    psel/penable    energy_threshold, alert_hold_ms, decay_period_ms
//
// One request per cycle unless i_req is held off; the result is registered in the
// execute stage, then in the output register that drives o_rsp. i_req is held off
// while a sweep-end sample is in the execute stage, since it may start a decay; a
// triggered decay walk over the peak RAM holds i_req off until the walk is done.
// After reset a clearing pass writes zero to every peak entry.
// An o_rsp stall holds the output register; a stalled result holds its request in stage.
module peak_hold_channel_activity_monitor #(
    parameter int NUM_CHANNELS = phm_pkg::NUM_CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    phm_stream_if.sink                     i_req,
    phm_stream_if.source                   o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [phm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import phm_pkg::*;

    localparam int IDX_W = $clog2(NUM_CHANNELS);
    localparam int CTR_W = $clog2(NUM_CHANNELS + 1);

    t_cfg cfg;

    phm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // peak RAM
    logic [5:0]       r_mem [NUM_CHANNELS];
    logic [5:0]       r_rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [5:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    // walk sequencer
    t_walk_state      r_state, n_state;
    logic [CTR_W-1:0] r_idx, n_idx;
    logic             r_dw_valid;
    logic [IDX_W-1:0] r_dw_idx;

    // execute stage
    logic             r_s_valid;
    t_in_item         r_s;
    logic             r_s_inrange;
    logic [IDX_W-1:0] r_s_addr;

    // scalar state
    logic [12:0]      r_energy, n_energy;
    logic [15:0]      r_ms_alert, n_ms_alert;
    logic [15:0]      r_ms_decay, n_ms_decay;

    // output register
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        out_item;

    logic             accept;
    logic             out_free;
    logic             s_adv;
    logic             s_last_smp;
    logic             in_range;
    logic [IDX_W-1:0] req_addr;
    logic             smp_wr;
    logic             decay_go;
    logic [13:0]      e_sum;
    logic [12:0]      e_sat;
    logic             raise;
    logic [5:0]       new_peak;

    assign accept     = i_req.valid && i_req.ready;
    assign out_free   = !r_out_valid || o_rsp.ready;
    assign s_adv      = r_s_valid && out_free;
    assign s_last_smp = r_s_valid && (r_s.cmd == CMD_SAMPLE) && r_s.sweep_end;
    // hold off the next request while a sweep-end sample may start a decay walk
    assign i_req.ready = (r_state == ST_RUN) && (!r_s_valid || s_adv) && !s_last_smp;

    assign in_range = 32'(i_req.payload.channel) < 32'(NUM_CHANNELS);
    assign req_addr = IDX_W'(i_req.payload.channel);

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // execute: peak raise, energy, timers, result
    always_comb begin
        e_sum      = {1'b0, r_energy} + 14'(r_s.carrier_count);
        e_sat      = e_sum[13] ? ENERGY_MAX : e_sum[12:0];
        raise      = r_s.carrier_count > r_rd_data;
        new_peak   = raise ? r_s.carrier_count : r_rd_data;
        n_energy   = r_energy;
        n_ms_alert = r_ms_alert;
        n_ms_decay = r_ms_decay;
        smp_wr     = 1'b0;
        decay_go   = 1'b0;
        out_item.peak_level   = '0;
        out_item.sweep_energy = r_energy;
        if (r_s.cmd == CMD_TICK) begin
            n_ms_alert = (r_ms_alert == MS_MAX) ? MS_MAX : r_ms_alert + 16'd1;
            n_ms_decay = (r_ms_decay == MS_MAX) ? MS_MAX : r_ms_decay + 16'd1;
        end else begin
            out_item.sweep_energy = e_sat;
            n_energy = e_sat;
            if (r_s_inrange) begin
                smp_wr = raise;
                out_item.peak_level = new_peak;
            end
            if (r_s.sweep_end) begin
                n_energy = '0;
                if (e_sat > cfg.energy_threshold) n_ms_alert = '0;
                if (r_ms_decay > cfg.decay_period_ms) begin
                    decay_go   = 1'b1;
                    n_ms_decay = '0;
                end
            end
        end
        out_item.alert_active = n_ms_alert < cfg.alert_hold_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // sequencer next state plus RAM port steering
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_s_addr;
        wr_data = r_s.carrier_count;
        rd_en   = 1'b0;
        rd_addr = req_addr;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[IDX_W-1:0];
                wr_data = '0;
                n_idx   = r_idx + CTR_W'(1);
                if (r_idx == CTR_W'(NUM_CHANNELS - 1)) begin
                    n_state = ST_RUN;
                    n_idx   = '0;
                end
            end
            ST_RUN: begin
                wr_en = s_adv && smp_wr;
                rd_en = accept && in_range;
                if (s_adv && decay_go) begin
                    n_state = ST_DECAY;
                    n_idx   = '0;
                end
            end
            ST_DECAY: begin
                // read entry k while writing back entry k-1
                rd_en   = r_idx < CTR_W'(NUM_CHANNELS);
                rd_addr = r_idx[IDX_W-1:0];
                wr_en   = r_dw_valid;
                wr_addr = r_dw_idx;
                wr_data = r_rd_data - 6'(r_rd_data != '0);
                n_idx   = r_idx + CTR_W'(1);
                if (r_idx == CTR_W'(NUM_CHANNELS)) begin
                    n_state = ST_RUN;
                    n_idx   = '0;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    // same-edge write to the read address is passed through
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= (wr_en && wr_addr == rd_addr) ? wr_data : r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dw_valid <= 1'b0;
        end else begin
            r_dw_valid <= (r_state == ST_DECAY) && rd_en;
        end
        r_dw_idx <= r_idx[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_energy    <= '0;
            r_ms_alert  <= '0;
            r_ms_decay  <= '0;
        end else begin
            if (accept) r_s_valid <= 1'b1;
            else if (s_adv) r_s_valid <= 1'b0;
            if (s_adv) begin
                r_out_valid <= 1'b1;
                r_energy    <= n_energy;
                r_ms_alert  <= n_ms_alert;
                r_ms_decay  <= n_ms_decay;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s         <= i_req.payload;
            r_s_inrange <= in_range;
            r_s_addr    <= req_addr;
        end
        if (s_adv) r_out <= out_item;
    end

    a_no_req_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !i_req.ready)
        else $error("request taken during clear or decay walk");

    a_decay_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && s_adv && decay_go) |=> (r_state == ST_DECAY && r_idx == '0))
        else $error("decay walk did not start");

    a_sweep_clears_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_adv && s_last_smp) |=> (r_energy == '0))
        else $error("energy total not cleared at sweep end");

    a_no_req_behind_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_last_smp |-> !accept)
        else $error("request accepted behind a sweep-end sample");

    a_walk_write_in_decay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dw_valid |-> (r_state == ST_DECAY && !r_s_valid))
        else $error("decay write-back outside decay walk");

endmodule
